>>> rtl/jhmp_pkg.sv
`default_nettype none

package jhmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_SEGMENT = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Marker codes that the scanner treats specially
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_STUFF  = 8'h00;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF15  = 8'hCF;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_JPG    = 8'hC8;
  localparam logic [7:0] MK_DAC    = 8'hCC;
  localparam logic [7:0] MK_APP0   = 8'hE0;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_APP2   = 8'hE2;
  localparam logic [7:0] MK_APP3   = 8'hE3;
  localparam logic [7:0] MK_APP14  = 8'hEE;
  localparam logic [7:0] MK_APP15  = 8'hEF;

  // Flag bits in found_flags
  localparam logic [3:0] FLAG_JFIF  = 4'b0001;
  localparam logic [3:0] FLAG_APP14 = 4'b0010;
  localparam logic [3:0] FLAG_ICC   = 4'b0100;
  localparam logic [3:0] FLAG_EXIF  = 4'b1000;

  // Signature strings, first byte in the top bits
  localparam logic [39:0] SIG_APP0  = 40'h4A_46_49_46_00;
  localparam logic [39:0] SIG_APP1  = 40'h45_78_69_66_00;
  localparam logic [39:0] SIG_APP14 = 40'h41_64_6F_62_65;
  localparam logic [95:0] SIG_APP2  = 96'h49_43_43_5F_50_52_4F_46_49_4C_45_00;

  localparam logic [3:0]  SIG_SHORT_LEN = 4'd5;
  localparam logic [3:0]  SIG_ICC_LEN   = 4'd12;
  localparam logic [15:0] SIG_ICC_MIN   = 16'd14;

  // JFIF resolution handling
  localparam logic [7:0]  UNITS_INCH  = 8'd1;
  localparam logic [7:0]  UNITS_CM    = 8'd2;
  localparam logic [9:0]  CM_TO_INCH  = 10'd650;
  localparam logic [25:0] DPI_DEFAULT = 26'd18432;

  localparam logic [3:0] OFF_UNITS  = 4'd7;
  localparam logic [3:0] OFF_XD_HI  = 4'd8;
  localparam logic [3:0] OFF_XD_LO  = 4'd9;
  localparam logic [3:0] OFF_YD_HI  = 4'd10;
  localparam logic [3:0] OFF_YD_LO  = 4'd11;
  localparam logic [3:0] FRAME_LAST = 4'd5;

  localparam int unsigned SKIP_BOUND_DEFAULT = 256;
  localparam int unsigned FIFO_DEPTH         = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  marker_code;
    logic [11:0] segment_index;
    logic        skip_segment;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  sample_precision;
    logic [7:0]  component_count;
    logic [3:0]  found_flags;
    logic [25:0] x_dpi;
    logic [25:0] y_dpi;
    logic        last_of_run;
  } result_t;

  // Results raised by one byte: up to two, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

  function automatic logic is_sof(input logic [7:0] code);
    begin
      is_sof = (code >= MK_SOF0) && (code <= MK_SOF15) &&
               (code != MK_DHT) && (code != MK_JPG) && (code != MK_DAC);
    end
  endfunction

  function automatic logic is_standalone(input logic [7:0] code);
    begin
      is_standalone = (code == MK_SOI) || ((code >= MK_RST0) && (code <= MK_RST7));
    end
  endfunction

  // Length of the signature window for a segment, 0 when none is checked
  function automatic logic [3:0] sig_window(input logic [7:0] code,
                                            input logic [15:0] len);
    begin
      unique case (code)
        MK_APP0, MK_APP1, MK_APP14:
          sig_window = (len > 16'(SIG_SHORT_LEN)) ? SIG_SHORT_LEN : 4'd0;
        MK_APP2:
          sig_window = (len >= SIG_ICC_MIN) ? SIG_ICC_LEN : 4'd0;
        default:
          sig_window = 4'd0;
      endcase
    end
  endfunction

  // Expected signature byte at a payload offset inside the window
  function automatic logic [7:0] sig_byte(input logic [7:0] code,
                                          input logic [3:0] off);
    logic [95:0] sig;
    logic [3:0]  pos;
    begin
      unique case (code)
        MK_APP0:  sig = {SIG_APP0, 56'h0};
        MK_APP1:  sig = {SIG_APP1, 56'h0};
        MK_APP14: sig = {SIG_APP14, 56'h0};
        default:  sig = SIG_APP2;
      endcase
      pos = (off < SIG_ICC_LEN) ? off : 4'd0;
      sig_byte = sig[8 * (11 - pos) +: 8];
    end
  endfunction

  function automatic logic [3:0] sig_flag(input logic [7:0] code);
    begin
      unique case (code)
        MK_APP0:  sig_flag = FLAG_JFIF;
        MK_APP14: sig_flag = FLAG_APP14;
        MK_APP2:  sig_flag = FLAG_ICC;
        default:  sig_flag = FLAG_EXIF;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/jpeg_header_marker_parser_unit.sv
`default_nettype none

// JPEG marker scanner: takes one file byte per transaction and walks the marker
// structure up to the first frame header, reporting one record per segment
// (with its drop mark below SKIP_BOUND), the frame geometry, the signature flags
// and the JFIF resolution. A byte is taken every cycle unless the input stalls:
// it is held in an input register, the parser updates its state from it, and the
// results it raises (one, or two when end of stream follows a record) go into a
// four-entry result queue. The input stalls only while that queue has fewer than
// two free places, so the sustained rate is one byte per cycle whenever results
// are taken as fast as they are made. Results pass the input register, then the queue.
module jpeg_header_marker_parser_unit #(
  parameter int unsigned SKIP_BOUND = jhmp_pkg::SKIP_BOUND_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       marker_code,
  output logic [11:0]      segment_index,
  output logic             skip_segment,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [7:0]       sample_precision,
  output logic [7:0]       component_count,
  output logic [3:0]       found_flags,
  output logic [25:0]      x_dpi,
  output logic [25:0]      y_dpi,
  output logic             last_of_run
);

  logic                 stage_valid;
  logic [7:0]           stage_byte;
  logic                 stage_eos;
  logic                 room_for_two;
  logic                 step;
  jhmp_pkg::parse_out_t results;
  jhmp_pkg::result_t    head;

  assign step     = stage_valid && room_for_two;
  assign in_ready = !stage_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
      stage_eos  <= end_of_stream;
    end
  end

  jhmp_parser #(
    .SKIP_BOUND (SKIP_BOUND)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (stage_byte),
    .end_of_stream (stage_eos),
    .results       (results)
  );

  jhmp_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (results),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .head         (head)
  );

  // Result fields
  assign kind             = head.kind;
  assign marker_code      = head.marker_code;
  assign segment_index    = head.segment_index;
  assign skip_segment     = head.skip_segment;
  assign image_width      = head.image_width;
  assign image_height     = head.image_height;
  assign sample_precision = head.sample_precision;
  assign component_count  = head.component_count;
  assign found_flags      = head.found_flags;
  assign x_dpi            = head.x_dpi;
  assign y_dpi            = head.y_dpi;
  assign last_of_run      = head.last_of_run;

endmodule

`default_nettype wire

>>> rtl/jhmp_parser.sv
`default_nettype none

module jhmp_parser #(
  parameter int unsigned SKIP_BOUND = jhmp_pkg::SKIP_BOUND_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 end_of_stream,
  output jhmp_pkg::parse_out_t      results
);

  localparam logic [12:0] SKIP_LIMIT = 13'(SKIP_BOUND);

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_FRAME,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [3:0]  offset, offset_next;
  logic [7:0]  marker, marker_next;
  logic [11:0] ordinal, ordinal_next;
  logic        sig_match, sig_match_next;
  logic [3:0]  sig_win, sig_win_next;
  logic [3:0]  flags, flags_next;
  logic [7:0]  units, units_next;
  logic [15:0] dens_x, dens_x_next;
  logic [15:0] dens_y, dens_y_next;
  logic [25:0] dpi_x, dpi_x_next;
  logic [25:0] dpi_y, dpi_y_next;
  logic [7:0]  precision, precision_next;
  logic [15:0] height, height_next;
  logic [15:0] width, width_next;
  logic [7:0]  comps, comps_next;

  function automatic logic [11:0] sat_inc(input logic [11:0] v);
    begin
      sat_inc = (v == 12'hFFF) ? v : v + 12'd1;
    end
  endfunction

  function automatic logic [25:0] to_dpi(input logic [7:0] u, input logic [15:0] d);
    begin
      if (u == jhmp_pkg::UNITS_INCH) begin
        to_dpi = {2'b00, d, 8'h00};
      end else if (u == jhmp_pkg::UNITS_CM) begin
        to_dpi = 26'(d) * 26'(jhmp_pkg::CM_TO_INCH);
      end else begin
        to_dpi = jhmp_pkg::DPI_DEFAULT;
      end
    end
  endfunction

  // Drop mark of a finished segment
  function automatic logic seg_skip(input logic [7:0] code, input logic [3:0] win,
                                    input logic match, input logic [11:0] ord);
    logic s;
    begin
      if (code == jhmp_pkg::MK_APP2) begin
        s = (win != 4'd0) && match;
      end else if (code == jhmp_pkg::MK_APP14) begin
        s = (win != 4'd0) && !match;
      end else begin
        s = (code >= jhmp_pkg::MK_APP3) && (code <= jhmp_pkg::MK_APP15);
      end
      if ({1'b0, ord} >= SKIP_LIMIT) begin
        s = 1'b0;
      end
      seg_skip = s;
    end
  endfunction

  function automatic jhmp_pkg::result_t make_rec(
      input logic [1:0] kind, input logic [7:0] code, input logic [11:0] idx,
      input logic skip, input logic [3:0] fl, input logic [25:0] dx,
      input logic [25:0] dy);
    jhmp_pkg::result_t r;
    begin
      r = '0;
      r.kind          = kind;
      r.marker_code   = code;
      r.segment_index = idx;
      r.skip_segment  = skip;
      r.found_flags   = fl;
      r.x_dpi         = dx;
      r.y_dpi         = dy;
      make_rec = r;
    end
  endfunction

  // Per-byte state update and result generation
  jhmp_pkg::result_t rec_a, rec_b;
  logic              have_a, have_b;
  logic [15:0]       len_full, len_pay;
  logic              seg_done;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    offset_next    = offset;
    marker_next    = marker;
    ordinal_next   = ordinal;
    sig_match_next = sig_match;
    sig_win_next   = sig_win;
    flags_next     = flags;
    units_next     = units;
    dens_x_next    = dens_x;
    dens_y_next    = dens_y;
    dpi_x_next     = dpi_x;
    dpi_y_next     = dpi_y;
    precision_next = precision;
    height_next    = height;
    width_next     = width;
    comps_next     = comps;
    rec_a          = '0;
    rec_b          = '0;
    have_a         = 1'b0;
    have_b         = 1'b0;
    seg_done       = 1'b0;
    len_full       = {remaining[15:8], data_byte};
    len_pay        = (len_full >= 16'd2) ? len_full - 16'd2 : 16'd0;

    unique case (phase)
      PH_PREFIX: begin
        if (data_byte == jhmp_pkg::MK_PREFIX) begin
          phase_next = PH_CODE;
        end else begin
          have_a     = 1'b1;
          rec_a      = make_rec(jhmp_pkg::KIND_ERROR, marker, ordinal, 1'b0,
                                flags, dpi_x, dpi_y);
          phase_next = PH_DONE;
        end
      end
      PH_CODE: begin
        if (data_byte != jhmp_pkg::MK_STUFF && data_byte != jhmp_pkg::MK_PREFIX) begin
          marker_next = data_byte;
          if (jhmp_pkg::is_standalone(data_byte)) begin
            have_a       = 1'b1;
            rec_a        = make_rec(jhmp_pkg::KIND_SEGMENT, data_byte, ordinal, 1'b0,
                                    flags, dpi_x, dpi_y);
            ordinal_next = sat_inc(ordinal);
            phase_next   = PH_PREFIX;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        remaining_next = {data_byte, 8'h00};
        phase_next     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        offset_next = 4'd0;
        if (jhmp_pkg::is_sof(marker)) begin
          precision_next = 8'd0;
          height_next    = 16'd0;
          width_next     = 16'd0;
          comps_next     = 8'd0;
          phase_next     = PH_FRAME;
        end else begin
          remaining_next = len_pay;
          sig_win_next   = jhmp_pkg::sig_window(marker, len_pay);
          sig_match_next = (sig_win_next != 4'd0);
          phase_next     = PH_PAYLOAD;
          seg_done       = (len_pay == 16'd0);
        end
      end
      PH_PAYLOAD: begin
        // Signature window
        if (offset < sig_win) begin
          if (jhmp_pkg::sig_byte(marker, offset) != data_byte) begin
            sig_match_next = 1'b0;
          end
          if ((offset + 4'd1 == sig_win) && sig_match_next) begin
            flags_next = flags | jhmp_pkg::sig_flag(marker);
          end
        end
        // JFIF resolution fields
        if (marker == jhmp_pkg::MK_APP0 && sig_win != 4'd0 && sig_match_next) begin
          unique case (offset)
            jhmp_pkg::OFF_UNITS: units_next = data_byte;
            jhmp_pkg::OFF_XD_HI: dens_x_next = {data_byte, 8'h00};
            jhmp_pkg::OFF_XD_LO: dens_x_next = {dens_x[15:8], data_byte};
            jhmp_pkg::OFF_YD_HI: dens_y_next = {data_byte, 8'h00};
            jhmp_pkg::OFF_YD_LO: begin
              dens_y_next = {dens_y[15:8], data_byte};
              dpi_x_next  = to_dpi(units, dens_x);
              dpi_y_next  = to_dpi(units, dens_y_next);
            end
            default: ;
          endcase
        end
        offset_next    = (offset == 4'hF) ? offset : offset + 4'd1;
        remaining_next = remaining - 16'd1;
        seg_done       = (remaining_next == 16'd0);
      end
      PH_FRAME: begin
        unique case (offset)
          4'd0:    precision_next = data_byte;
          4'd1:    height_next = {data_byte, 8'h00};
          4'd2:    height_next = {height[15:8], data_byte};
          4'd3:    width_next = {data_byte, 8'h00};
          4'd4:    width_next = {width[15:8], data_byte};
          default: comps_next = data_byte;
        endcase
        offset_next = offset + 4'd1;
        if (offset == jhmp_pkg::FRAME_LAST) begin
          have_a                 = 1'b1;
          rec_a                  = make_rec(jhmp_pkg::KIND_FRAME, marker, ordinal,
                                            1'b0, flags_next, dpi_x_next, dpi_y_next);
          rec_a.image_width      = width_next;
          rec_a.image_height     = height_next;
          rec_a.sample_precision = precision_next;
          rec_a.component_count  = comps_next;
          phase_next             = PH_DONE;
        end
      end
      default: ;
    endcase

    // End of a segment with a length
    if (seg_done) begin
      have_a       = 1'b1;
      rec_a        = make_rec(jhmp_pkg::KIND_SEGMENT, marker, ordinal,
                              seg_skip(marker, sig_win_next, sig_match_next, ordinal),
                              flags_next, dpi_x_next, dpi_y_next);
      ordinal_next = sat_inc(ordinal);
      phase_next   = PH_PREFIX;
    end

    // End of stream without a final result
    if (end_of_stream && phase_next != PH_DONE) begin
      have_b     = 1'b1;
      rec_b      = make_rec(jhmp_pkg::KIND_ERROR, marker_next, ordinal_next, 1'b0,
                            flags_next, dpi_x_next, dpi_y_next);
      phase_next = PH_DONE;
    end
  end

  // Order the results and mark the last one of the byte
  always_comb begin
    results = '0;
    if (have_a) begin
      results.first  = rec_a;
      results.second = rec_b;
      results.count  = have_b ? 2'd2 : 2'd1;
      if (have_b) begin
        results.second.last_of_run = 1'b1;
      end else begin
        results.first.last_of_run = 1'b1;
      end
    end else if (have_b) begin
      results.first             = rec_b;
      results.first.last_of_run = 1'b1;
      results.count             = 2'd1;
    end
    if (!step) begin
      results.count = 2'd0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PREFIX;
      remaining <= '0;
      offset    <= '0;
      marker    <= '0;
      ordinal   <= '0;
      sig_match <= 1'b1;
      sig_win   <= '0;
      flags     <= '0;
      units     <= '0;
      dens_x    <= '0;
      dens_y    <= '0;
      dpi_x     <= '0;
      dpi_y     <= '0;
      precision <= '0;
      height    <= '0;
      width     <= '0;
      comps     <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      offset    <= offset_next;
      marker    <= marker_next;
      ordinal   <= ordinal_next;
      sig_match <= sig_match_next;
      sig_win   <= sig_win_next;
      flags     <= flags_next;
      units     <= units_next;
      dens_x    <= dens_x_next;
      dens_y    <= dens_y_next;
      dpi_x     <= dpi_x_next;
      dpi_y     <= dpi_y_next;
      precision <= precision_next;
      height    <= height_next;
      width     <= width_next;
      comps     <= comps_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jhmp_result_fifo.sv
`default_nettype none

module jhmp_result_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  jhmp_pkg::parse_out_t      push,
  output logic                      room_for_two,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output jhmp_pkg::result_t         head
);

  localparam int unsigned PTR_W = $clog2(jhmp_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(jhmp_pkg::FIFO_DEPTH + 1);

  jhmp_pkg::result_t mem [jhmp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;
  logic              pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign head         = mem[rd_ptr];
  assign room_for_two = (count <= CNT_W'(jhmp_pkg::FIFO_DEPTH - 2));
  assign count_next   = count + CNT_W'(push.count) - CNT_W'(pop);

  // Storage: up to two writes per cycle at consecutive entries
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jhmp_checker.sv
`default_nettype none

module jhmp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic        skip_segment,
  input wire logic [15:0] image_width,
  input wire logic [7:0]  sample_precision,
  input wire logic        last_of_run
);

  // A stalled result keeps its kind
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("result changed while stalled");

  // Nothing follows a final result
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind != jhmp_pkg::KIND_SEGMENT |=> !out_valid)
    else $error("result after final transaction");

  // A final result ends its byte's run and carries no drop mark
  a_final_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != jhmp_pkg::KIND_SEGMENT |-> last_of_run && !skip_segment)
    else $error("final result fields wrong");

  // Frame fields only appear in a frame header result
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != jhmp_pkg::KIND_FRAME |->
      image_width == 16'd0 && sample_precision == 8'd0)
    else $error("frame fields in non-frame result");

endmodule

bind jpeg_header_marker_parser_unit jhmp_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .skip_segment     (skip_segment),
  .image_width      (image_width),
  .sample_precision (sample_precision),
  .last_of_run      (last_of_run)
);

`default_nettype wire
